// ===== rtl/core/hbs_pkg.sv =====
`default_nettype none

package hbs_pkg;

	localparam int MAX_DIM     = 128;
	localparam int HEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int COORD_BITS  = 20;
	localparam int DIM_BITS    = 8;
	localparam int GRID_DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_BITS   = $clog2(GRID_DEPTH);
	localparam int CELL_BITS   = COORD_BITS + 1 - FRAC_BITS;
	localparam int CFG_BITS    = 20;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_DIM);
	localparam logic signed [HEIGHT_BITS-1:0] OOR_HEIGHT = -(HEIGHT_BITS'(1) << FRAC_BITS);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_OFFSET   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Z_OFFSET   = 2'd3;

	typedef struct packed {
		logic                           opcode;
		logic [13:0]                    cell_index;
		logic signed [HEIGHT_BITS-1:0]  cell_height;
		logic signed [COORD_BITS-1:0]   query_x;
		logic signed [COORD_BITS-1:0]   query_z;
	} in_word_t;

	typedef struct packed {
		logic signed [HEIGHT_BITS-1:0]  sampled_height;
		logic                           out_of_range;
	} out_word_t;

	typedef enum logic [1:0] {
		ADR_00 = 2'd0,
		ADR_01 = 2'd1,
		ADR_10 = 2'd2,
		ADR_11 = 2'd3
	} addr_sel_t;

	typedef enum logic [1:0] {
		BL_ROW0 = 2'd0,
		BL_ROW1 = 2'd1,
		BL_COL  = 2'd2
	} blend_sel_t;

	typedef struct packed {
		logic       accept;
		logic       calc;
		logic       rd_en;
		addr_sel_t  rd_sel;
		logic       cap_h00;
		logic       cap_b0;
		logic       cap_h10;
		logic       cap_b1;
		logic       out_load;
		blend_sel_t blend_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic oor;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hbs_datapath.sv =====
`default_nettype none

module hbs_datapath (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire hbs_pkg::in_word_t                       in_data,
	input  wire logic                                    cfg_we,
	input  wire logic [hbs_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [hbs_pkg::CFG_BITS-1:0]            cfg_data,
	input  wire hbs_pkg::dp_cmd_t                        cmd,
	output hbs_pkg::dp_status_t                          sts,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output hbs_pkg::out_word_t                           out_data
);

	localparam int HB = hbs_pkg::HEIGHT_BITS;
	localparam int FB = hbs_pkg::FRAC_BITS;
	localparam int CB = hbs_pkg::COORD_BITS;
	localparam int AB = hbs_pkg::ADDR_BITS;
	localparam int NB = hbs_pkg::CELL_BITS;
	localparam int DB = hbs_pkg::DIM_BITS;
	localparam int PB = HB + FB + 2;

	logic [DB-1:0]          width_q;
	logic [DB-1:0]          height_q;
	logic signed [CB-1:0]   xoff_q;
	logic signed [CB-1:0]   zoff_q;

	logic signed [CB:0]     dx_q;
	logic signed [CB:0]     dz_q;
	logic [AB-1:0]          base_q;
	logic                   oor_q;
	logic signed [HB-1:0]   rd_q;
	logic signed [HB-1:0]   h00_q;
	logic signed [HB-1:0]   h10_q;
	logic signed [HB-1:0]   b0_q;
	logic signed [HB-1:0]   b1_q;
	logic                   out_valid_q;
	hbs_pkg::out_word_t     out_data_q;

	logic signed [HB-1:0]   grid_mem [hbs_pkg::GRID_DEPTH];

	logic [DB-1:0]          w_eff;
	logic [DB-1:0]          h_eff;
	logic signed [NB-1:0]   cx;
	logic signed [NB-1:0]   cz;
	logic signed [NB-1:0]   wm1;
	logic signed [NB-1:0]   hm1;
	logic [FB-1:0]          fx;
	logic [FB-1:0]          fz;
	logic [AB-1:0]          base_d;
	logic [AB-1:0]          rd_addr;
	logic [AB-1:0]          w_ext;

	logic signed [HB-1:0]   bl_a;
	logic signed [HB-1:0]   bl_b;
	logic [FB-1:0]          bl_f;
	logic signed [FB+1:0]   wt_a;
	logic signed [FB+1:0]   wt_b;
	logic signed [PB-1:0]   bl_sum;
	logic signed [HB-1:0]   bl_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hbs_pkg::DIM_RESET;
			height_q <= hbs_pkg::DIM_RESET;
			xoff_q   <= '0;
			zoff_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hbs_pkg::REG_MAP_WIDTH:  width_q  <= cfg_data[DB-1:0];
				hbs_pkg::REG_MAP_HEIGHT: height_q <= cfg_data[DB-1:0];
				hbs_pkg::REG_X_OFFSET:   xoff_q   <= cfg_data[CB-1:0];
				hbs_pkg::REG_Z_OFFSET:   zoff_q   <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q > DB'(hbs_pkg::MAX_DIM)) ? DB'(hbs_pkg::MAX_DIM) : width_q;
	assign h_eff = (height_q > DB'(hbs_pkg::MAX_DIM)) ? DB'(hbs_pkg::MAX_DIM) : height_q;

	assign cx  = dx_q[CB:FB];
	assign cz  = dz_q[CB:FB];
	assign fx  = dx_q[FB-1:0];
	assign fz  = dz_q[FB-1:0];
	assign wm1 = $signed(NB'(w_eff)) - NB'(1);
	assign hm1 = $signed(NB'(h_eff)) - NB'(1);

	assign sts.is_query = (in_data.opcode == hbs_pkg::OP_QUERY);
	assign sts.oor      = (cx <= 0) || (cz <= 0) || (cx >= wm1) || (cz >= hm1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign base_d = AB'(AB'(cx) + AB'(cz) * AB'(w_eff));
	assign w_ext  = AB'(w_eff);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dx_q <= (CB+1)'(in_data.query_x) - (CB+1)'(xoff_q);
			dz_q <= (CB+1)'(in_data.query_z) - (CB+1)'(zoff_q);
		end
		if (cmd.calc) begin
			base_q <= base_d;
			oor_q  <= sts.oor;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			hbs_pkg::ADR_00: rd_addr = base_q;
			hbs_pkg::ADR_01: rd_addr = base_q + w_ext;
			hbs_pkg::ADR_10: rd_addr = base_q + AB'(1);
			hbs_pkg::ADR_11: rd_addr = base_q + w_ext + AB'(1);
			default:         rd_addr = base_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_data.opcode == hbs_pkg::OP_WRITE))
			grid_mem[in_data.cell_index[AB-1:0]] <= in_data.cell_height;
		if (cmd.rd_en)
			rd_q <= grid_mem[rd_addr];
	end

	// shared lerp: (a*(1-f) + b*f) >> FRAC_BITS, floor
	always_comb begin
		case (cmd.blend_sel)
			hbs_pkg::BL_ROW0: begin
				bl_a = h00_q;
				bl_b = rd_q;
				bl_f = fz;
			end
			hbs_pkg::BL_ROW1: begin
				bl_a = h10_q;
				bl_b = rd_q;
				bl_f = fz;
			end
			hbs_pkg::BL_COL: begin
				bl_a = b0_q;
				bl_b = b1_q;
				bl_f = fx;
			end
			default: begin
				bl_a = b0_q;
				bl_b = b1_q;
				bl_f = fx;
			end
		endcase
		wt_b   = $signed({2'b00, bl_f});
		wt_a   = $signed((FB+2)'(1) << FB) - wt_b;
		bl_sum = (PB'(bl_a) * PB'(wt_a)) + (PB'(bl_b) * PB'(wt_b));
		bl_res = bl_sum[HB+FB-1:FB];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_h00)
			h00_q <= rd_q;
		if (cmd.cap_h10)
			h10_q <= rd_q;
		if (cmd.cap_b0)
			b0_q <= bl_res;
		if (cmd.cap_b1)
			b1_q <= bl_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.sampled_height <= oor_q ? hbs_pkg::OOR_HEIGHT : bl_res;
			out_data_q.out_of_range   <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_oor_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.out_of_range
			|-> out_data_q.sampled_height == hbs_pkg::OOR_HEIGHT)
		else $error("out of range word without -1.0 height");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_data_q))
		else $error("result word dropped or changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/hbs_ctrl.sv =====
`default_nettype none

module hbs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire hbs_pkg::dp_status_t  sts,
	output hbs_pkg::dp_cmd_t          cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CALC = 8'b0000_0010,
		ST_RD0  = 8'b0000_0100,
		ST_RD1  = 8'b0000_1000,
		ST_RD2  = 8'b0001_0000,
		ST_RD3  = 8'b0010_0000,
		ST_MIX  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && sts.out_free);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.rd_sel    = hbs_pkg::ADR_00;
		cmd.blend_sel = hbs_pkg::BL_COL;
		cmd.accept    = accept;
		state_d       = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.is_query)
					state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = sts.oor ? ST_FIN : ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = hbs_pkg::ADR_00;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = hbs_pkg::ADR_01;
				cmd.cap_h00 = 1'b1;
				state_d     = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = hbs_pkg::ADR_10;
				cmd.cap_b0    = 1'b1;
				cmd.blend_sel = hbs_pkg::BL_ROW0;
				state_d       = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = hbs_pkg::ADR_11;
				cmd.cap_h10 = 1'b1;
				state_d     = ST_MIX;
			end
			ST_MIX: begin
				cmd.cap_b1    = 1'b1;
				cmd.blend_sel = hbs_pkg::BL_ROW1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = (accept && sts.is_query) ? ST_CALC : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_oor_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) && sts.oor |=> state_q == ST_FIN)
		else $error("out of range query did not skip the grid reads");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sts.is_query |=> state_q == ST_CALC)
		else $error("accepted query did not start address step");

	a_no_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ready)
		else $error("input taken while grid is being read");

endmodule

`default_nettype wire

// ===== rtl/core/heightmap_bilinear_sampler_core.sv =====
// A write word is stored at acceptance and gives no result. A query goes through the
// address step, four reads of the grid's one read port with two row blends, and the
// column blend; the result loads once the output is free (off-grid queries skip reads).
// A new query is taken as the last result loads; writes are taken one per cycle while idle.
// Reset: arst_n clears control and config registers (sizes 128, offsets 0); the grid
// keeps no reset value and must be written before it is read.
`default_nettype none

module heightmap_bilinear_sampler_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire hbs_pkg::in_word_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output hbs_pkg::out_word_t                     out_data,
	input  wire logic                              cfg_we,
	input  wire logic [hbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [hbs_pkg::CFG_BITS-1:0]      cfg_data
);

	hbs_pkg::dp_cmd_t    cmd;
	hbs_pkg::dp_status_t sts;

	hbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hbs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
